// File: hw/rtl/heap_sorter_defines.svh
// ----------------------------------------------------------------------------
// heap_sorter_defines.svh
// Assertion macros shared by the heap sorter checkers.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORTER_DEFINES_SVH
`define HEAP_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define HS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap sorter check failed");

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define HS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap sorter check failed");

`endif

// File: hw/rtl/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared constants of the heap sorter.
// ----------------------------------------------------------------------------
package hs_pkg;

    // Width of one value to be sorted.
    localparam int DATA_W = 32;

    // Default number of values one run can hold.
    localparam int CAPACITY_DEF = 64;

endpackage

// File: hw/rtl/hs_if.sv
// ----------------------------------------------------------------------------
// hs_if
// Valid/ready stream interfaces for the heap sorter input and result beats.
// ----------------------------------------------------------------------------

// Input stream: one value per beat, is_last closes the set.
interface hs_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [hs_pkg::DATA_W-1:0] value;
    logic                            is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

// Result stream: one sorted value per beat.
interface hs_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [hs_pkg::DATA_W-1:0] sorted_value;
    logic                            final_res;
    logic                            truncated;

    modport source (output valid, output sorted_value, output final_res,
                    output truncated, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input truncated, output ready);
endinterface

// File: hw/rtl/hs_ram.sv
// ----------------------------------------------------------------------------
// hs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int DEPTH = hs_pkg::CAPACITY_DEF,
    parameter int AW    = 6,
    parameter int DW    = hs_pkg::DATA_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/heap_sorter.sv
// ----------------------------------------------------------------------------
// heap_sorter
// Collects signed values into a RAM and, on the closing beat, heapsorts them
// in place and streams them out in ascending order.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                 Beat accepted
// i_in     in   value[31:0] signed, is_last             valid && ready
// o_out    out  sorted_value[31:0] signed, final_res,   valid && ready
//               truncated
//
// Loading accepts a beat whenever i_in is valid in S_LOAD. A closing beat of
// n values starts the sort: each sift level takes a left read, a right read
// and a compare and write back over the single read port. Each result is
// read in S_EMIT_RD and registered in S_EMIT_LD. Reset clears only the state,
// fill count, overflow and phase flags and output valid; RAM needs no clearing.
// i_in is not ready while a run is sorted or emitted; a stalled o_out holds.
//
module heap_sorter #(
    parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hs_in_if.sink     i_in,
    hs_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;
    localparam int DW = hs_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BLD_RD,
        S_BLD_GET,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_CMP,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state                r_state;
    logic                  r_phase_sort;
    logic [CW-1:0]         r_fill;
    logic                  r_ovf;
    logic [CW-1:0]         r_n;
    logic                  r_trunc;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_hn;
    logic [CW-1:0]         r_k;
    logic [AW-1:0]         r_pos;
    logic signed [DW-1:0]  r_v;
    logic signed [DW-1:0]  r_tmp;
    logic signed [DW-1:0]  r_lval;
    logic                  r_out_valid;
    logic signed [DW-1:0]  r_out_value;
    logic                  r_out_final;
    logic                  r_out_trunc;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DW-1:0]         w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DW-1:0]         w_rdata;
    logic signed [DW-1:0]  w_rval;

    logic                  w_in_acc;
    logic                  w_room;
    logic [CW-1:0]         n_fill;
    logic [CW-1:0]         w_im1;
    logic [LW-1:0]         w_left;
    logic [LW-1:0]         w_right;
    logic [LW-1:0]         w_hn_ext;
    logic                  w_left_in;
    logic                  w_right_in;
    logic                  w_pick_r;
    logic signed [DW-1:0]  w_best_val;
    logic [LW-1:0]         w_best_idx;
    logic                  w_go;
    logic                  w_sift_done;
    logic                  w_emit_last;

    // Value store.
    hs_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rval = $signed(w_rdata);

    // Load-side bookkeeping.
    assign w_in_acc = i_in.valid && (r_state == S_LOAD);
    assign w_room   = (r_fill < CW'(CAPACITY));
    assign n_fill   = w_room ? (r_fill + CW'(1)) : r_fill;
    assign w_im1    = r_i - CW'(1);

    // Children of the current hole and the larger of them.
    assign w_left      = {1'b0, r_pos, 1'b1};
    assign w_right     = w_left + LW'(1);
    assign w_hn_ext    = LW'(r_hn);
    assign w_left_in   = (w_left < w_hn_ext);
    assign w_right_in  = (w_right < w_hn_ext);
    assign w_pick_r    = w_right_in && (w_rval > r_lval);
    assign w_best_val  = w_pick_r ? w_rval : r_lval;
    assign w_best_idx  = w_pick_r ? w_right : w_left;
    assign w_go        = (w_best_val > r_v);
    assign w_sift_done = ((r_state == S_SIFT_L) && !w_left_in) ||
                         ((r_state == S_SIFT_CMP) && !w_go);
    assign w_emit_last = ((r_k + CW'(1)) == r_n);

    // RAM port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_v;
        w_raddr = '0;
        case (r_state)
            S_LOAD: begin
                w_we    = w_in_acc && w_room;
                w_waddr = r_fill[AW-1:0];
                w_wdata = i_in.value;
            end
            S_BLD_RD: begin
                w_raddr = w_im1[AW-1:0];
            end
            S_SW_RD0: begin
                w_raddr = '0;
            end
            S_SW_RD1: begin
                w_raddr = r_i[AW-1:0];
            end
            S_SW_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_tmp;
            end
            S_SIFT_L: begin
                w_raddr = w_left[AW-1:0];
                w_we    = !w_left_in;
            end
            S_SIFT_R: begin
                w_raddr = w_right[AW-1:0];
            end
            S_SIFT_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_go ? w_best_val : r_v;
            end
            S_EMIT_RD: begin
                w_raddr = r_k[AW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Sequencer: load, heap build, sort-down and emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_phase_sort <= 1'b0;
            r_fill       <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // A finished sift walks to the next build root, the next sort-down swap
            // or, after the last swap, to emit.
            if (w_sift_done) begin
                if (!r_phase_sort) begin
                    if (r_i == CW'(1)) begin
                        r_phase_sort <= 1'b1;
                        r_i          <= r_n - CW'(1);
                        r_state      <= S_SW_RD0;
                    end else begin
                        r_i     <= w_im1;
                        r_state <= S_BLD_RD;
                    end
                end else begin
                    if (r_i == CW'(1)) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_i     <= w_im1;
                        r_state <= S_SW_RD0;
                    end
                end
            end

            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (i_in.is_last) begin
                            r_n          <= n_fill;
                            r_trunc      <= r_ovf || !w_room;
                            r_fill       <= '0;
                            r_ovf        <= 1'b0;
                            r_phase_sort <= 1'b0;
                            if (n_fill < CW'(2)) begin
                                r_k     <= '0;
                                r_state <= S_EMIT_RD;
                            end else begin
                                r_i     <= n_fill >> 1;
                                r_state <= S_BLD_RD;
                            end
                        end else begin
                            r_fill <= n_fill;
                            r_ovf  <= r_ovf || !w_room;
                        end
                    end
                end
                S_BLD_RD: begin
                    r_pos   <= w_im1[AW-1:0];
                    r_hn    <= r_n;
                    r_state <= S_BLD_GET;
                end
                S_BLD_GET: begin
                    r_v     <= w_rval;
                    r_state <= S_SIFT_L;
                end
                S_SW_RD0: begin
                    r_state <= S_SW_RD1;
                end
                S_SW_RD1: begin
                    r_tmp   <= w_rval;
                    r_state <= S_SW_WR;
                end
                S_SW_WR: begin
                    r_v     <= w_rval;
                    r_hn    <= r_i;
                    r_pos   <= '0;
                    r_state <= S_SIFT_L;
                end
                S_SIFT_L: begin
                    if (w_left_in) begin
                        r_state <= S_SIFT_R;
                    end
                end
                S_SIFT_R: begin
                    r_lval  <= w_rval;
                    r_state <= S_SIFT_CMP;
                end
                S_SIFT_CMP: begin
                    if (w_go) begin
                        r_pos   <= w_best_idx[AW-1:0];
                        r_state <= S_SIFT_L;
                    end
                end
                S_EMIT_RD: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_EMIT_LD;
                    end
                end
                S_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= w_rval;
                    r_out_final <= w_emit_last;
                    r_out_trunc <= r_trunc;
                    if (w_emit_last) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Port drive.
    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.final_res    = r_out_final;
    assign o_out.truncated    = r_out_trunc;

endmodule

// File: hw/rtl/hs_checker.sv
// ----------------------------------------------------------------------------
// hs_checker
// Port-level checks of the heap sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "heap_sorter_defines.svh"

module hs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_in_is_last,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic signed [hs_pkg::DATA_W-1:0] i_out_value,
    input logic                            i_out_final,
    input logic                            i_out_trunc
);

    logic                        w_in_beat;
    logic                        w_out_stall;
    logic [hs_pkg::DATA_W+1:0]   w_out_word;

    assign w_in_beat   = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_out_word  = {i_out_value, i_out_final, i_out_trunc};

    // A stalled result beat keeps its payload.
    `HS_ASSERT_NEXT(a_out_hold, w_out_stall, i_out_valid && $stable(w_out_word))

    // Input is closed while a run still has results to come.
    `HS_ASSERT_NOW(a_busy_emit, i_out_valid && !i_out_final, !i_in_ready)

    // The closing beat stops intake for at least the next cycle.
    `HS_ASSERT_NEXT(a_last_blocks, w_in_beat && i_in_is_last, !i_in_ready)

    // Loading a value that does not close the set never starts a result.
    `HS_ASSERT_NEXT(a_no_early_out, w_in_beat && !i_in_is_last, !$rose(i_out_valid))

endmodule

bind heap_sorter hs_checker u_hs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_is_last (i_in.is_last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.sorted_value),
    .i_out_final  (o_out.final_res),
    .i_out_trunc  (o_out.truncated)
);
